>>> hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the checker files
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked outside reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked at every edge, reset included.
`define ASSERT_NXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> hw/rtl/mkh_pkg.sv
// ---------------------------------------------------------------------------
// mkh_pkg
// Types, constants and helpers of the murmur3 key hash block.
// ---------------------------------------------------------------------------
package mkh_pkg;

    localparam int S_TDATA_W = 40;   // data_word, byte_count, zero fill
    localparam int M_TDATA_W = 64;   // hash_value, bucket_index
    localparam int CFG_IDX_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_SEED  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TSIZE = 8'd1;

    localparam logic [31:0] SEED_RST  = 32'd42;
    localparam logic [31:0] TSIZE_RST = 32'd37;

    localparam logic [31:0] MM_C1 = 32'hcc9e2d51;
    localparam logic [31:0] MM_C2 = 32'h1b873593;
    localparam logic [31:0] MM_N  = 32'he6546b64;
    localparam logic [31:0] MM_F1 = 32'h85ebca6b;
    localparam logic [31:0] MM_F2 = 32'hc2b2ae35;

    // One classified chunk as it sits in the queue
    typedef struct packed {
        logic [31:0] word;      // already masked for a tail
        logic [2:0]  len_inc;   // bytes added to the key length
        logic        is_block;  // full block mix, else tail mix
        logic        last;
    } t_chunk;

    typedef enum logic [3:0] {
        B_IDLE,
        B_SCR1,
        B_SCR2,
        B_MIX,
        B_FIN1,
        B_FIN2,
        B_FIN3,
        B_DIV,
        B_OUT
    } t_bstate;

    function automatic logic [31:0] rotl15(input logic [31:0] x);
        rotl15 = {x[16:0], x[31:17]};
    endfunction

    function automatic logic [31:0] rotl13(input logic [31:0] x);
        rotl13 = {x[18:0], x[31:19]};
    endfunction

    function automatic logic [31:0] tail_mask(input logic [1:0] cnt);
        logic [31:0] m;
        case (cnt)
            2'd0:    m = 32'h0000_0000;
            2'd1:    m = 32'h0000_00ff;
            2'd2:    m = 32'h0000_ffff;
            default: m = 32'h00ff_ffff;
        endcase
        tail_mask = m;
    endfunction

endpackage

>>> hw/rtl/mkh_front.sv
// ---------------------------------------------------------------------------
// mkh_front
// Accepts chunks, classifies them as block or tail, and queues them.
// ---------------------------------------------------------------------------
module mkh_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [31:0]       i_word,
    input  logic [2:0]        i_count,
    input  logic              i_last,
    output mkh_pkg::t_chunk   o_head,
    output logic              o_head_valid,
    input  logic              i_pop
);

    mkh_pkg::t_chunk r_q [2];
    logic            r_wptr, n_wptr;
    logic            r_rptr, n_rptr;
    logic [1:0]      r_cnt, n_cnt;
    mkh_pkg::t_chunk w_cls;
    logic            w_push;
    logic            w_pop;

    // count of 4..7 or a non-last chunk means a full block
    always_comb begin
        w_cls.last     = i_last;
        w_cls.is_block = !i_last || i_count[2];
        if (w_cls.is_block) begin
            w_cls.word    = i_word;
            w_cls.len_inc = 3'd4;
        end else begin
            w_cls.word    = i_word & mkh_pkg::tail_mask(i_count[1:0]);
            w_cls.len_inc = i_count;
        end
    end

    assign o_ready      = (r_cnt != 2'd2);
    assign w_push       = i_valid && o_ready;
    assign o_head_valid = (r_cnt != 2'd0);
    assign w_pop        = i_pop && o_head_valid;
    assign o_head       = r_q[r_rptr];

    always_comb begin
        n_wptr = r_wptr ^ w_push;
        n_rptr = r_rptr ^ w_pop;
        n_cnt  = r_cnt + {1'b0, w_push} - {1'b0, w_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wptr] <= w_cls;
        end
    end

endmodule

>>> hw/rtl/mkh_back.sv
// ---------------------------------------------------------------------------
// mkh_back
// Sequencer for block mix, final mix and bucket modulo; one shared multiplier.
// ---------------------------------------------------------------------------
module mkh_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [31:0]       i_seed,
    input  logic [31:0]       i_tsize,
    input  mkh_pkg::t_chunk   i_head,
    input  logic              i_head_valid,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [31:0]       o_hash,
    output logic [31:0]       o_bucket
);

    mkh_pkg::t_bstate r_state, n_state;
    mkh_pkg::t_chunk  r_item;
    logic [31:0]      r_acc;
    logic [31:0]      r_hash;
    logic [31:0]      r_len;
    logic             r_active;
    logic [31:0]      r_fhash;
    logic [31:0]      r_dvd;
    logic [31:0]      r_rem;
    logic [4:0]       r_dcnt;
    logic             r_ovalid;
    logic [31:0]      r_ohash;
    logic [31:0]      r_obucket;

    logic [31:0]      w_mul_a, w_mul_b, w_prod;
    logic             w_out_load;
    logic             w_out_free;
    logic [31:0]      w_hbase, w_lbase, w_len_new;
    logic [31:0]      w_hx, w_hrot, w_h1;
    logic [32:0]      w_rem_sh;
    logic [32:0]      w_rem_sub;
    logic [31:0]      w_rem_nx;
    logic [31:0]      w_fin3;

    assign w_out_free = !r_ovalid || i_ready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mkh_pkg::B_IDLE: if (i_head_valid) n_state = mkh_pkg::B_SCR1;
            mkh_pkg::B_SCR1: n_state = mkh_pkg::B_SCR2;
            mkh_pkg::B_SCR2: n_state = mkh_pkg::B_MIX;
            mkh_pkg::B_MIX:  n_state = r_item.last ? mkh_pkg::B_FIN1 : mkh_pkg::B_IDLE;
            mkh_pkg::B_FIN1: n_state = mkh_pkg::B_FIN2;
            mkh_pkg::B_FIN2: n_state = mkh_pkg::B_FIN3;
            mkh_pkg::B_FIN3: n_state = mkh_pkg::B_DIV;
            mkh_pkg::B_DIV:  if (r_dcnt == 5'd0) n_state = mkh_pkg::B_OUT;
            mkh_pkg::B_OUT:  if (w_out_free) n_state = mkh_pkg::B_IDLE;
            default:         n_state = mkh_pkg::B_IDLE;
        endcase
    end

    // outputs: queue pop, multiplier operands, result load
    always_comb begin
        o_pop      = 1'b0;
        w_out_load = 1'b0;
        w_mul_a    = r_acc ^ {16'd0, r_acc[31:16]};
        w_mul_b    = mkh_pkg::MM_F1;
        unique case (r_state)
            mkh_pkg::B_IDLE: o_pop = i_head_valid;
            mkh_pkg::B_SCR1: begin
                w_mul_a = r_item.word;
                w_mul_b = mkh_pkg::MM_C1;
            end
            mkh_pkg::B_SCR2: begin
                w_mul_a = mkh_pkg::rotl15(r_acc);
                w_mul_b = mkh_pkg::MM_C2;
            end
            mkh_pkg::B_FIN2: begin
                w_mul_a = r_acc ^ {13'd0, r_acc[31:13]};
                w_mul_b = mkh_pkg::MM_F2;
            end
            mkh_pkg::B_OUT: w_out_load = w_out_free;
            default: ;
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;

    // block / tail mix; a new key starts from the seed
    always_comb begin
        w_hbase   = r_active ? r_hash : i_seed;
        w_lbase   = r_active ? r_len  : 32'd0;
        w_len_new = w_lbase + {29'd0, r_item.len_inc};
        w_hx      = w_hbase ^ r_acc;
        w_hrot    = mkh_pkg::rotl13(w_hx);
        if (r_item.is_block) begin
            w_h1 = {w_hrot[29:0], 2'b00} + w_hrot + mkh_pkg::MM_N;
        end else begin
            w_h1 = w_hx;
        end
    end

    assign w_fin3 = r_acc ^ {16'd0, r_acc[31:16]};

    // one remainder bit per cycle; zero table size leaves the hash itself
    always_comb begin
        w_rem_sh  = {r_rem, r_dvd[31]};
        w_rem_sub = w_rem_sh - {1'b0, i_tsize};
        if (w_rem_sh >= {1'b0, i_tsize}) begin
            w_rem_nx = w_rem_sub[31:0];
        end else begin
            w_rem_nx = w_rem_sh[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= mkh_pkg::B_IDLE;
            r_active <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == mkh_pkg::B_MIX) begin
                r_active <= !r_item.last;
            end
            if (w_out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= i_head;
        end
        case (r_state)
            mkh_pkg::B_SCR1, mkh_pkg::B_SCR2,
            mkh_pkg::B_FIN1, mkh_pkg::B_FIN2: r_acc <= w_prod;
            mkh_pkg::B_MIX: begin
                r_hash <= w_h1;
                r_len  <= w_len_new;
                r_acc  <= w_h1 ^ w_len_new;
            end
            mkh_pkg::B_FIN3: begin
                r_fhash <= w_fin3;
                r_dvd   <= w_fin3;
                r_rem   <= 32'd0;
                r_dcnt  <= 5'd31;
            end
            mkh_pkg::B_DIV: begin
                r_rem  <= w_rem_nx;
                r_dvd  <= {r_dvd[30:0], 1'b0};
                r_dcnt <= r_dcnt - 5'd1;
            end
            default: ;
        endcase
        if (w_out_load) begin
            r_ohash   <= r_fhash;
            r_obucket <= r_rem;
        end
    end

    assign o_valid  = r_ovalid;
    assign o_hash   = r_ohash;
    assign o_bucket = r_obucket;

endmodule

>>> hw/rtl/murmur3_32_key_hash.sv
// ---------------------------------------------------------------------------
// murmur3_32_key_hash
// Streaming MurmurHash3 x86_32 of a key, with bucket index modulo table size.
// ---------------------------------------------------------------------------
//  channel   direction  payload
//  s_axis    in         tdata[31:0] data_word, tdata[34:32] byte_count,
//                       tlast last_chunk
//  m_axis    out        tdata[31:0] hash_value, tdata[63:32] bucket_index
//  cfg       in         index 0 seed, index 1 table_size, i_cfg_data value
//
//  A non-last chunk passes the back end as pop, two scramble
//  multiplies, mix. A last chunk adds three final-mix steps (two on the
//  shared multiplier), a bit-serial modulo and one load.
//  A two-entry request queue lets the front accept while the back works.
//  Reset is synchronous; the seed takes effect at the start of the next key.
// ---------------------------------------------------------------------------
module murmur3_32_key_hash (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [31:0] data_word, [34:32] byte_count, [39:35] zero
    input  logic [mkh_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    input  logic                            s_axis_tlast,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [31:0] hash_value, [63:32] bucket_index
    output logic [mkh_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [mkh_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [31:0]                     i_cfg_data
);

    logic [31:0]     r_seed;
    logic [31:0]     r_tsize;
    mkh_pkg::t_chunk w_head;
    logic            w_head_valid;
    logic            w_pop;
    logic [31:0]     w_hash;
    logic [31:0]     w_bucket;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed  <= mkh_pkg::SEED_RST;
            r_tsize <= mkh_pkg::TSIZE_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                mkh_pkg::REG_SEED:  r_seed  <= i_cfg_data;
                mkh_pkg::REG_TSIZE: r_tsize <= i_cfg_data;
                default: ;
            endcase
        end
    end

    mkh_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_word       (s_axis_tdata[31:0]),
        .i_count      (s_axis_tdata[34:32]),
        .i_last       (s_axis_tlast),
        .o_head       (w_head),
        .o_head_valid (w_head_valid),
        .i_pop        (w_pop)
    );

    mkh_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_seed       (r_seed),
        .i_tsize      (r_tsize),
        .i_head       (w_head),
        .i_head_valid (w_head_valid),
        .o_pop        (w_pop),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_hash       (w_hash),
        .o_bucket     (w_bucket)
    );

    assign m_axis_tdata = {w_bucket, w_hash};

endmodule

>>> hw/rtl/mkh_checker.sv
// ---------------------------------------------------------------------------
// mkh_checker
// Port-level checks of the key hash block, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module mkh_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    input  logic [mkh_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic [mkh_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    input  logic                            i_cfg_valid,
    input  logic                            o_cfg_ready,
    input  logic [mkh_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [31:0]                     i_cfg_data
);

    logic [31:0] r_tsize;
    logic        w_zero_ts;
    logic        w_ins;
    logic        w_ts_wr;
    logic        w_stall;
    logic [31:0] w_hash;
    logic [31:0] w_bucket;

    assign w_ts_wr = i_cfg_valid && o_cfg_ready && (i_cfg_index == mkh_pkg::REG_TSIZE);

    // shadow of the table size as seen on the config port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tsize <= mkh_pkg::TSIZE_RST;
        end else if (w_ts_wr) begin
            r_tsize <= i_cfg_data;
        end
    end

    assign w_zero_ts = (r_tsize == 32'd0);
    assign w_ins     = s_axis_tvalid && s_axis_tready && (s_axis_tdata[39:35] != 5'd0);
    assign w_stall   = m_axis_tvalid && !m_axis_tready;
    assign w_hash    = m_axis_tdata[31:0];
    assign w_bucket  = m_axis_tdata[63:32];

    `ASSERT_NXT(a_out_hold, i_clk, i_rst_n, w_stall, m_axis_tvalid && $stable(m_axis_tdata))
    `ASSERT_IMP(a_bucket_range, i_clk, i_rst_n, m_axis_tvalid && !w_zero_ts, w_bucket < r_tsize)
    `ASSERT_IMP(a_bucket_zero_ts, i_clk, i_rst_n, m_axis_tvalid && w_zero_ts, w_bucket == w_hash)
    `ASSERT_NXT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n, !m_axis_tvalid && !w_ins)

endmodule

bind murmur3_32_key_hash mkh_checker u_mkh_checker (.*);
